FILE: design/buddy_page_allocator_macros.svh
// ---------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Short forms for the concurrent checks in the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bpa_pkg.sv
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Shared widths, codes, types and helper functions.
// ---------------------------------------------------------------------------
package bpa_pkg;

    localparam int BPA_MAX_PAGES = 4096;
    localparam int CFG_W         = 4;
    localparam int REQ_W         = 13;
    localparam int OFF_W         = 12;
    localparam int STAT_W        = 2;
    localparam int ORD_W         = 5;
    localparam int RESET_ORDER   = 12;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD      = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_DESC,
        S_ASC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             bad;
        logic             is_free;
        logic [ORD_W-1:0] ord;
    } t_req_dec;

    // Largest k with 2^k <= v.
    function automatic int f_floor_log2(input int v);
        int k;
        k = 0;
        for (int i = 0; i < 30; i++) begin
            if ((64'd1 << (i + 1)) <= 64'(v)) begin
                k = i + 1;
            end
        end
        return k;
    endfunction

    // Order of the power of two that a page count rounds up to.
    function automatic logic [ORD_W-1:0] f_ceil_log2_req(input logic [REQ_W-1:0] r);
        logic [REQ_W-1:0] m;
        logic [ORD_W-1:0] k;
        m = r - REQ_W'(1);
        k = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if (m[i]) begin
                k = ORD_W'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

FILE: design/buddy_page_allocator.sv
// ---------------------------------------------------------------------------
// Buddy page allocator
// Binary buddy tree of longest free runs kept in one synchronous memory.
// ---------------------------------------------------------------------------
// An allocate walks down from the root to the rounded order K, then refreshes
// the parents back up; a free restores its node and merges upward to the root;
// a rejected or no-space request goes straight to the result. One transaction
// at a time; the next is accepted only after the result is registered.
// The tree walk reads each level through the registered memory read ports.
// Reset and every pool_order write rebuild all 2^(N+1)-1 nodes, N the pool order.
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int MAX_PAGES = BPA_MAX_PAGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_pool_order,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_action,
    input  logic [REQ_W-1:0]  i_request_pages,
    input  logic [OFF_W-1:0]  i_block_offset,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [OFF_W-1:0]  o_granted_offset,
    output logic [REQ_W-1:0]  o_granted_pages
);

`include "buddy_page_allocator_macros.svh"

    localparam int MAX_ORDER = f_floor_log2(MAX_PAGES);
    localparam int AW        = MAX_ORDER + 1;       // node index width
    localparam int VW        = MAX_ORDER + 1;       // run length width
    localparam int OFW       = MAX_ORDER;           // page offset width
    localparam int DEPTH     = 1 << AW;
    localparam logic [ORD_W-1:0] RST_PO =
        ORD_W'((RESET_ORDER < MAX_ORDER) ? RESET_ORDER : MAX_ORDER);

    // Tree storage: node i at depth d covers 2^(N-d) pages.
    logic [VW-1:0] r_mem [0:DEPTH-1];
    logic [VW-1:0] r_rd_a;
    logic [VW-1:0] r_rd_b;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [VW-1:0] mem_wd;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;

    // control state
    t_state           r_state,     n_state;
    logic [ORD_W-1:0] r_po,        n_po;
    logic [AW-1:0]    r_init_addr, n_init_addr;
    logic [VW-1:0]    r_init_val,  n_init_val;
    logic             r_o_valid,   n_o_valid;

    // transaction context
    logic             r_is_free,   n_is_free;
    logic             r_bad,       n_bad;
    logic [ORD_W-1:0] r_sk,        n_sk;
    logic [AW-1:0]    r_fidx,      n_fidx;
    logic [AW-1:0]    r_idx,       n_idx;
    logic [ORD_W-1:0] r_ord,       n_ord;
    logic [VW-1:0]    r_val,       n_val;
    logic [OFW-1:0]   r_off,       n_off;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [OFF_W-1:0]  r_res_off,    n_res_off;
    logic [REQ_W-1:0]  r_res_pages,  n_res_pages;
    logic [STAT_W-1:0] r_o_status,   n_o_status;
    logic [OFF_W-1:0]  r_o_off,      n_o_off;
    logic [REQ_W-1:0]  r_o_pages,    n_o_pages;

    t_req_dec         dec;
    logic [AW-1:0]    dec_idx;
    logic [ORD_W-1:0] cfg_eff;
    logic [AW-1:0]    init_last;
    logic [VW-1:0]    size;
    logic [REQ_W-1:0] size_pages;

    // descent / ascent helpers
    logic [AW-1:0]    left_idx;
    logic             pick_right;
    logic [AW-1:0]    child_idx;
    logic [ORD_W-1:0] child_ord;
    logic [OFW-1:0]   child_off;
    logic [AW-1:0]    parent_idx;
    logic [VW-1:0]    half_size;
    logic [VW-1:0]    run_max;
    logic [VW-1:0]    parent_val;

    bpa_req_decode #(
        .MAX_PAGES (MAX_PAGES)
    ) u_req_decode (
        .i_action        (i_action),
        .i_request_pages (i_request_pages),
        .i_block_offset  (i_block_offset),
        .i_pool_order    (r_po),
        .o_dec           (dec),
        .o_free_idx      (dec_idx)
    );

    // Hold off new requests while anything is in flight or being configured.
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_granted_offset = r_o_off;
    assign o_granted_pages  = r_o_pages;

    always_comb begin
        cfg_eff = (ORD_W'(i_cfg_pool_order) > ORD_W'(MAX_ORDER)) ?
                  ORD_W'(MAX_ORDER) : ORD_W'(i_cfg_pool_order);
        // last node of the pool's tree: 2^(N+1) - 2
        init_last  = ~({AW{1'b1}} << (r_po + ORD_W'(1))) - AW'(1);
        size       = VW'(1) << r_sk;
        size_pages = REQ_W'(1) << r_sk;

        // descent: r_rd_a / r_rd_b hold the children of r_idx
        left_idx   = {r_idx[AW-2:0], 1'b1};
        if ((r_rd_a >= size) && (r_rd_b >= size)) begin
            // both fit: take the tighter run, left on a tie
            pick_right = r_rd_a > r_rd_b;
        end else begin
            pick_right = r_rd_a < r_rd_b;
        end
        child_idx  = left_idx + AW'(pick_right);
        child_ord  = r_ord - ORD_W'(1);
        child_off  = pick_right ? (r_off | (OFW'(1) << child_ord)) : r_off;

        // ascent: r_rd_a holds the sibling of r_idx, r_val its fresh value
        parent_idx = (r_idx - AW'(1)) >> 1;
        half_size  = VW'(1) << r_ord;
        run_max    = (r_val > r_rd_a) ? r_val : r_rd_a;
        if (r_is_free && (r_val == half_size) && (r_rd_a == half_size)) begin
            parent_val = half_size << 1;     // two free buddies merge
        end else begin
            parent_val = run_max;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_po         = r_po;
        n_init_addr  = r_init_addr;
        n_init_val   = r_init_val;
        n_is_free    = r_is_free;
        n_bad        = r_bad;
        n_sk         = r_sk;
        n_fidx       = r_fidx;
        n_idx        = r_idx;
        n_ord        = r_ord;
        n_val        = r_val;
        n_off        = r_off;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_res_pages  = r_res_pages;
        n_o_valid    = r_o_valid && i_out_stall;
        n_o_status   = r_o_status;
        n_o_off      = r_o_off;
        n_o_pages    = r_o_pages;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        rd_a_addr    = '0;
        rd_b_addr    = '0;

        case (r_state)
            S_INIT: begin
                // sweep the pool's nodes, halving the run at each level start
                mem_we = 1'b1;
                mem_wa = r_init_addr;
                mem_wd = r_init_val;
                if (r_init_addr == init_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_init_addr = r_init_addr + AW'(1);
                    if (((r_init_addr + AW'(2)) & (r_init_addr + AW'(1))) == '0) begin
                        n_init_val = r_init_val >> 1;
                    end
                end
            end
            S_IDLE: begin
                // root read goes out by default on port A
                if (i_in_valid && !o_in_stall) begin
                    n_is_free = dec.is_free;
                    n_bad     = dec.bad;
                    n_sk      = dec.ord;
                    n_fidx    = dec_idx;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res_off = '0;
                if (r_bad) begin
                    n_res_status = STAT_BAD;
                    n_res_pages  = '0;
                    n_state      = S_DONE;
                end else if (!r_is_free) begin
                    n_res_pages = size_pages;
                    if (r_rd_a < size) begin
                        n_res_status = STAT_NO_SPACE;
                        n_state      = S_DONE;
                    end else if (r_po == r_sk) begin
                        // whole pool: take the root
                        mem_we       = 1'b1;
                        mem_wa       = '0;
                        mem_wd       = '0;
                        n_res_status = STAT_OK;
                        n_state      = S_DONE;
                    end else begin
                        rd_a_addr = AW'(1);
                        rd_b_addr = AW'(2);
                        n_idx     = '0;
                        n_ord     = r_po;
                        n_off     = '0;
                        n_state   = S_DESC;
                    end
                end else begin
                    // free: restore the node, then merge upward
                    mem_we       = 1'b1;
                    mem_wa       = r_fidx;
                    mem_wd       = size;
                    n_res_status = STAT_OK;
                    n_res_pages  = size_pages;
                    if (r_fidx == '0) begin
                        n_state = S_DONE;
                    end else begin
                        rd_a_addr = r_fidx[0] ? (r_fidx + AW'(1)) : (r_fidx - AW'(1));
                        n_idx     = r_fidx;
                        n_val     = size;
                        n_ord     = r_sk;
                        n_state   = S_ASC;
                    end
                end
            end
            S_DESC: begin
                n_idx = child_idx;
                n_ord = child_ord;
                n_off = child_off;
                if (child_ord == r_sk) begin
                    // found the block: mark it used, start the refresh
                    mem_we       = 1'b1;
                    mem_wa       = child_idx;
                    mem_wd       = '0;
                    n_val        = '0;
                    n_res_status = STAT_OK;
                    n_res_off    = OFF_W'(child_off);
                    rd_a_addr    = child_idx[0] ? (child_idx + AW'(1)) :
                                                  (child_idx - AW'(1));
                    n_state      = S_ASC;
                end else begin
                    rd_a_addr = {child_idx[AW-2:0], 1'b1};
                    rd_b_addr = {child_idx[AW-2:0], 1'b0} + AW'(2);
                end
            end
            S_ASC: begin
                mem_we = 1'b1;
                mem_wa = parent_idx;
                mem_wd = parent_val;
                if (parent_idx == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_idx     = parent_idx;
                    n_val     = parent_val;
                    n_ord     = r_ord + ORD_W'(1);
                    rd_a_addr = parent_idx[0] ? (parent_idx + AW'(1)) :
                                                (parent_idx - AW'(1));
                end
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_off    = r_res_off;
                    n_o_pages  = r_res_pages;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        // A pool_order write rebuilds the tree from scratch.
        if (i_cfg_valid) begin
            n_po        = cfg_eff;
            n_state     = S_INIT;
            n_init_addr = '0;
            n_init_val  = VW'(1) << cfg_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_po        <= RST_PO;
            r_init_addr <= '0;
            r_init_val  <= VW'(1) << RST_PO;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_po        <= n_po;
            r_init_addr <= n_init_addr;
            r_init_val  <= n_init_val;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_free    <= n_is_free;
        r_bad        <= n_bad;
        r_sk         <= n_sk;
        r_fidx       <= n_fidx;
        r_idx        <= n_idx;
        r_ord        <= n_ord;
        r_val        <= n_val;
        r_off        <= n_off;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_res_pages  <= n_res_pages;
        r_o_status   <= n_o_status;
        r_o_off      <= n_o_off;
        r_o_pages    <= n_o_pages;
    end

    // Tree memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_mem[rd_a_addr];
        r_rd_b <= r_mem[rd_b_addr];
    end

    // Checks

    `BPA_ASSERT_NEXT(a_accept_to_check, i_in_valid && !o_in_stall && !i_cfg_valid, r_state == S_CHECK, "accepted transaction did not enter the check step")
    `BPA_ASSERT_NOW(a_no_rw_overlap, mem_we && (n_state == S_ASC), mem_wa != rd_a_addr, "refresh reads the node it is writing")
    `BPA_ASSERT_NOW(a_desc_above_target, r_state == S_DESC, r_ord > r_sk, "descent went below the requested level")
    `BPA_ASSERT_NOW(a_asc_below_root, r_state == S_ASC, r_ord < r_po, "refresh climbed above the root")
    `BPA_ASSERT_NOW(a_result_from_done, $rose(o_out_valid), $past(r_state) == S_DONE, "result appeared outside the done step")

endmodule

FILE: design/bpa_req_decode.sv
// ---------------------------------------------------------------------------
// Buddy page allocator request decode
// Rounds the page count, checks the request and locates the node to free.
// ---------------------------------------------------------------------------
module bpa_req_decode import bpa_pkg::*; #(
    parameter int MAX_PAGES = BPA_MAX_PAGES
) (
    input  logic             i_action,
    input  logic [REQ_W-1:0] i_request_pages,
    input  logic [OFF_W-1:0] i_block_offset,
    input  logic [ORD_W-1:0] i_pool_order,
    output t_req_dec         o_dec,
    output logic [f_floor_log2(MAX_PAGES):0] o_free_idx
);

    localparam int MAX_ORDER = f_floor_log2(MAX_PAGES);
    localparam int AW        = MAX_ORDER + 1;

    logic [ORD_W-1:0] req_ord;
    logic [ORD_W-1:0] lvl_diff;
    logic [OFF_W-1:0] off_shift;
    logic [OFF_W-1:0] off_low;
    logic             off_range_bad;
    logic             off_align_bad;

    always_comb begin
        req_ord       = f_ceil_log2_req(i_request_pages);
        lvl_diff      = i_pool_order - req_ord;
        off_shift     = i_block_offset >> req_ord;
        off_low       = i_block_offset & ~({OFF_W{1'b1}} << req_ord);
        off_range_bad = (i_block_offset >> i_pool_order) != '0;
        off_align_bad = off_low != '0;

        o_dec.is_free = i_action;
        o_dec.ord     = req_ord;
        o_dec.bad     = (i_request_pages == '0) || (req_ord > i_pool_order) ||
                        (i_action && (off_range_bad || off_align_bad));

        // first node of the level plus the block's place in that level
        o_free_idx    = (AW'(1) << lvl_diff) - AW'(1) + AW'(off_shift);
    end

endmodule
